FILE: rtl/ccc_pkg.sv
// ----------------------------------------------------------------------------
// ccc_pkg
// Shared types, constants and month length lookup for the calendar counter.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int MS_PER_SEC   = 1000;
  localparam int SEC_PER_MIN  = 60;
  localparam int MIN_PER_HOUR = 60;
  localparam int HOUR_PER_DAY = 24;
  localparam int MONTHS       = 12;
  localparam int FEB_LEAP     = 29;
  localparam int FEB_COMMON   = 28;
  localparam int LONG_MONTH   = 31;
  localparam logic [1:0] LEAP_MASK = 2'b11;
  localparam logic [3:0] MONTH_FEB = 4'd1;

  localparam int OUT_DATA_W   = 56;

  typedef struct packed {
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic        synced;
  } cal_t;

  function automatic logic [4:0] month_len(input logic [3:0] month);
    logic [4:0] len;
    case (month)
      4'd0:    len = 5'd31;
      4'd1:    len = 5'd28;
      4'd2:    len = 5'd31;
      4'd3:    len = 5'd30;
      4'd4:    len = 5'd31;
      4'd5:    len = 5'd30;
      4'd6:    len = 5'd31;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd30;
      4'd9:    len = 5'd31;
      4'd10:   len = 5'd30;
      4'd11:   len = 5'd31;
      default: len = 5'(LONG_MONTH);
    endcase
    return len;
  endfunction

endpackage

FILE: rtl/ccc_step.sv
// ----------------------------------------------------------------------------
// ccc_step
// One-second advance of the calendar: second, minute, hour, day, month and
// year cascade with month lengths and leap February.
// ----------------------------------------------------------------------------
module ccc_step
  import ccc_pkg::*;
(
  input  cal_t cal_i,
  output cal_t cal_o
);

  logic       sec_wrap;
  logic       min_wrap;
  logic       hour_wrap;
  logic       day_wrap;
  logic       mon_wrap;
  logic [4:0] days;

  always_comb begin
    if (cal_i.month == MONTH_FEB) begin
      days = ((cal_i.year[1:0] & LEAP_MASK) == 2'b00) ? 5'(FEB_LEAP) : 5'(FEB_COMMON);
    end else begin
      days = month_len(cal_i.month);
    end

    sec_wrap  = cal_i.second >= 6'(SEC_PER_MIN - 1);
    min_wrap  = cal_i.minute >= 6'(MIN_PER_HOUR - 1);
    hour_wrap = cal_i.hour >= 5'(HOUR_PER_DAY - 1);
    day_wrap  = cal_i.day >= (days - 5'd1);
    mon_wrap  = cal_i.month >= 4'(MONTHS - 1);

    cal_o = cal_i;
    cal_o.second = sec_wrap ? 6'd0 : cal_i.second + 6'd1;
    if (sec_wrap) begin
      cal_o.minute = min_wrap ? 6'd0 : cal_i.minute + 6'd1;
      if (min_wrap) begin
        cal_o.hour = hour_wrap ? 5'd0 : cal_i.hour + 5'd1;
        if (hour_wrap) begin
          cal_o.synced = 1'b0;
          cal_o.day    = day_wrap ? 5'd0 : cal_i.day + 5'd1;
          if (day_wrap) begin
            cal_o.month = mon_wrap ? 4'd0 : cal_i.month + 4'd1;
            if (mon_wrap) begin
              cal_o.year = cal_i.year + 16'd1;
            end
          end
        end
      end
    end
  end

endmodule

FILE: rtl/calendar_clock_counter_top.sv
// ----------------------------------------------------------------------------
// calendar_clock_counter_top
// Calendar clock with millisecond advance and date/time load.
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (low bit up)                         | tuser
// in_     | in  | elapsed_ms, set_year, set_month, set_day,         | cmd
//         |     | set_hour, set_minute, set_second                  |
// out_    | out | cur_year, cur_month, cur_day, cur_hour,           | -
//         |     | cur_minute, cur_second, cur_millis, synced        |
//
// A load passes ST_DONE to the result register; an advance first loops in
// ST_RUN over the S whole seconds carried, one per cycle through the shared
// one-second step and subtract-1000 unit (up to 66 at the default width).
// Synchronous active-low reset clears the calendar to zero, not synced.
// in_tready is low while an item is in work; the result register lets the
// next item start while a result waits for out_tready.
// ----------------------------------------------------------------------------
module calendar_clock_counter_top
  import ccc_pkg::*;
#(
  parameter int ELAPSED_WIDTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // elapsed_ms, set_year, set_month, set_day, set_hour, set_minute, set_second
  input  logic [((ELAPSED_WIDTH+42+7)/8)*8-1:0] in_tdata,
  // cmd
  input  logic                       in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // cur_year, cur_month, cur_day, cur_hour, cur_minute, cur_second,
  // cur_millis, synced
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int ACC_W = ELAPSED_WIDTH + 1;
  localparam int SY    = ELAPSED_WIDTH;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  cal_t                   cal_r, cal_nxt;
  cal_t                   cal_step;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]  out_data_r, out_data_nxt;
  logic                   in_fire;
  logic                   has_sec;
  cal_t                   cal_load;

  ccc_step u_step (
    .cal_i (cal_r),
    .cal_o (cal_step)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign has_sec    = acc_r >= ACC_W'(MS_PER_SEC);

  always_comb begin
    cal_load.year   = in_tdata[SY+15:SY];
    cal_load.month  = in_tdata[SY+19:SY+16];
    cal_load.day    = in_tdata[SY+24:SY+20];
    cal_load.hour   = in_tdata[SY+29:SY+25];
    cal_load.minute = in_tdata[SY+35:SY+30];
    cal_load.second = in_tdata[SY+41:SY+36];
    cal_load.synced = 1'b1;
  end

  always_comb begin
    state_nxt     = state_r;
    cal_nxt       = cal_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser) begin
            cal_nxt   = cal_load;
            acc_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            acc_nxt   = acc_r + ACC_W'(in_tdata[ELAPSED_WIDTH-1:0]);
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (has_sec) begin
          acc_nxt = acc_r - ACC_W'(MS_PER_SEC);
          cal_nxt = cal_step;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, cal_r.synced, acc_r[9:0], cal_r.second, cal_r.minute,
                           cal_r.hour, cal_r.day, cal_r.month, cal_r.year};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cal_r       <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cal_r       <= cal_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
